FILE: hw/rtl/sos_pkg.sv
// shared types, constants and coefficient selection for the saw oscillator smoother
package sos_pkg;

    localparam int RING_DEPTH = 8;
    localparam int RING_IDX_W = 3;
    localparam int NUM_COEFS  = 8;
    localparam int COEF_IDX_W = 3;
    localparam int PHASE_W    = 19;
    localparam int TAP_W      = 18;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = 34;
    localparam int ACC_W      = 37;
    localparam int ACC_LO_W   = 18;
    localparam int ACC_HI_W   = 19;
    localparam int PLO_W      = 33;
    localparam int PHI_W      = 35;
    localparam int SCALED_W   = 53;
    localparam int QUOT_W     = 22;
    localparam int SAMPLE_W   = 16;
    localparam int STEP_W     = 16;
    localparam int AMP_W      = 15;
    localparam int DATA_W     = 64;
    localparam int ADDR_W     = 5;
    localparam int REG_IDX_W  = 2;

    localparam logic signed [PHASE_W-1:0] PHASE_ONE = 19'sd65536;
    localparam logic signed [PHASE_W-1:0] PHASE_TWO = 19'sd131072;
    localparam logic signed [QUOT_W-1:0]  SAT_MAX   = 22'sd32767;
    localparam logic signed [QUOT_W-1:0]  SAT_MIN   = -22'sd32768;

    localparam logic [STEP_W-1:0] PHASE_STEP_RST = 16'd983;
    localparam logic [AMP_W-1:0]  AMPLITUDE_RST  = 15'd500;
    localparam logic [DATA_W-1:0] TAPS_LOW_RST   = 64'd2951364347294941512;
    localparam logic [DATA_W-1:0] TAPS_HIGH_RST  = 64'd92335011425298358;

    localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TAPS_LOW   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_TAPS_HIGH  = 2'd3;

    typedef struct packed {
        logic [STEP_W-1:0] phase_step;
        logic [AMP_W-1:0]  amplitude;
        logic [DATA_W-1:0] taps_low;
        logic [DATA_W-1:0] taps_high;
    } sos_cfg_t;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_PHASE,
        ENG_MAC,
        ENG_SCALE_LO,
        ENG_SCALE_HI,
        ENG_FINISH
    } eng_state_t;

    function automatic logic signed [COEF_W-1:0] coef_at(
        input logic [DATA_W-1:0]     taps_low,
        input logic [DATA_W-1:0]     taps_high,
        input logic [COEF_IDX_W-1:0] idx
    );
        logic [DATA_W-1:0] word;
        word = idx[2] ? taps_high : taps_low;
        case (idx[1:0])
            2'd0:    coef_at = signed'(word[15:0]);
            2'd1:    coef_at = signed'(word[31:16]);
            2'd2:    coef_at = signed'(word[47:32]);
            default: coef_at = signed'(word[63:48]);
        endcase
    endfunction

endpackage

FILE: hw/rtl/sos_ram.sv
// generic single write port ram with registered read
module sos_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/sos_regs.sv
// apb configuration registers
module sos_regs
    import sos_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output sos_cfg_t          cfg
);

    sos_cfg_t              cfg_reg;
    sos_cfg_t              cfg_next;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  wr_en;

    assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_PHASE_STEP: cfg_next.phase_step = pwdata[STEP_W-1:0];
                REG_AMPLITUDE:  cfg_next.amplitude  = pwdata[AMP_W-1:0];
                REG_TAPS_LOW:   cfg_next.taps_low   = pwdata;
                REG_TAPS_HIGH:  cfg_next.taps_high  = pwdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PHASE_STEP: prdata = DATA_W'(cfg_reg.phase_step);
            REG_AMPLITUDE:  prdata = DATA_W'(cfg_reg.amplitude);
            REG_TAPS_LOW:   prdata = cfg_reg.taps_low;
            REG_TAPS_HIGH:  prdata = cfg_reg.taps_high;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.phase_step <= PHASE_STEP_RST;
            cfg_reg.amplitude  <= AMPLITUDE_RST;
            cfg_reg.taps_low   <= TAPS_LOW_RST;
            cfg_reg.taps_high  <= TAPS_HIGH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hw/rtl/sos_engine.sv
// phase update, tap ring and shared multiply-accumulate sequencer
module sos_engine
    import sos_pkg::*;
#(
    parameter int NUM_TAPS = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sos_cfg_t                   cfg,
    input  logic                       start,
    output logic                       busy,
    output logic signed [SAMPLE_W-1:0] held_sample
);

    localparam int CNT_W = $clog2(NUM_TAPS + 1);

    eng_state_t                   state_reg, state_next;
    logic signed [PHASE_W-1:0]    phase_reg, phase_next;
    logic [RING_IDX_W-1:0]        slot_reg, slot_next;
    logic signed [SAMPLE_W-1:0]   held_reg, held_next;
    logic [RING_DEPTH-1:0]        live_reg, live_next;
    logic [CNT_W-1:0]             iss_reg, iss_next;
    logic                         rd_pend_reg, rd_pend_next;
    logic                         mul_pend_reg, mul_pend_next;
    logic [COEF_IDX_W-1:0]        rd_tap_reg, rd_tap_next;
    logic                         rd_live_reg, rd_live_next;
    logic signed [PROD_W-1:0]     prod_reg, prod_next;
    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic [PLO_W-1:0]             plo_reg, plo_next;
    logic signed [PHI_W-1:0]      phi_reg, phi_next;

    logic                         ram_we;
    logic [RING_IDX_W-1:0]        ram_raddr;
    logic [TAP_W-1:0]             ram_rdata;
    logic signed [PHASE_W-1:0]    phase_sum;
    logic signed [PHASE_W-1:0]    phase_wrap;
    logic signed [TAP_W-1:0]      tap_val;
    logic signed [COEF_W-1:0]     coef;
    logic [COEF_IDX_W-1:0]        iss_tap;
    logic signed [ACC_HI_W-1:0]   acc_hi;
    logic signed [AMP_W:0]        amp_s;
    logic signed [SCALED_W-1:0]   scaled;
    logic signed [QUOT_W-1:0]     quot;
    logic signed [QUOT_W-1:0]     quot_adj;

    sos_ram #(
        .WIDTH (TAP_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (phase_wrap[TAP_W-1:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy        = (state_reg != ENG_IDLE);
    assign held_sample = held_reg;

    assign phase_sum  = phase_reg + signed'(PHASE_W'(cfg.phase_step));
    assign phase_wrap = (phase_sum > PHASE_ONE) ? (phase_sum - PHASE_TWO) : phase_sum;
    assign iss_tap    = COEF_IDX_W'(iss_reg);
    assign ram_raddr  = slot_reg - RING_IDX_W'(iss_tap);
    assign tap_val    = rd_live_reg ? signed'(ram_rdata) : '0;
    assign coef       = coef_at(cfg.taps_low, cfg.taps_high, rd_tap_reg);
    assign acc_hi     = acc_reg[ACC_W-1:ACC_LO_W];
    assign amp_s      = signed'({1'b0, cfg.amplitude});
    assign scaled     = (SCALED_W'(phi_reg) <<< ACC_LO_W) + signed'(SCALED_W'(plo_reg));
    assign quot       = scaled[SCALED_W-1:SCALED_W-QUOT_W];
    assign quot_adj   = quot + QUOT_W'(scaled[SCALED_W-1] && (|scaled[30:0]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ENG_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        slot_next     = slot_reg;
        held_next     = held_reg;
        live_next     = live_reg;
        iss_next      = iss_reg;
        rd_pend_next  = 1'b0;
        mul_pend_next = 1'b0;
        rd_tap_next   = rd_tap_reg;
        rd_live_next  = rd_live_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        plo_next      = plo_reg;
        phi_next      = phi_reg;
        ram_we        = 1'b0;
        case (state_reg)
            ENG_IDLE: begin
                if (start) begin
                    state_next = ENG_PHASE;
                end
            end
            ENG_PHASE: begin
                phase_next          = phase_wrap;
                ram_we              = 1'b1;
                live_next[slot_reg] = 1'b1;
                iss_next            = '0;
                acc_next            = '0;
                state_next          = ENG_MAC;
            end
            ENG_MAC: begin
                if (iss_reg < CNT_W'(NUM_TAPS)) begin
                    rd_pend_next = 1'b1;
                    rd_tap_next  = iss_tap;
                    rd_live_next = live_reg[ram_raddr];
                    iss_next     = iss_reg + 1'b1;
                end
                if (rd_pend_reg) begin
                    prod_next     = PROD_W'(coef) * PROD_W'(tap_val);
                    mul_pend_next = 1'b1;
                end
                if (mul_pend_reg) begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                end
                if (iss_reg == CNT_W'(NUM_TAPS) && !rd_pend_reg && !mul_pend_reg) begin
                    state_next = ENG_SCALE_LO;
                end
            end
            ENG_SCALE_LO: begin
                plo_next   = PLO_W'(acc_reg[ACC_LO_W-1:0]) * PLO_W'(cfg.amplitude);
                state_next = ENG_SCALE_HI;
            end
            ENG_SCALE_HI: begin
                phi_next   = PHI_W'(acc_hi) * PHI_W'(amp_s);
                state_next = ENG_FINISH;
            end
            ENG_FINISH: begin
                if (quot_adj > SAT_MAX) begin
                    held_next = SAT_MAX[SAMPLE_W-1:0];
                end else if (quot_adj < SAT_MIN) begin
                    held_next = SAT_MIN[SAMPLE_W-1:0];
                end else begin
                    held_next = quot_adj[SAMPLE_W-1:0];
                end
                slot_next  = slot_reg + 1'b1;
                state_next = ENG_IDLE;
            end
            default: begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= '0;
            slot_reg     <= '0;
            held_reg     <= '0;
            live_reg     <= '0;
            iss_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            mul_pend_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            slot_reg     <= slot_next;
            held_reg     <= held_next;
            live_reg     <= live_next;
            iss_reg      <= iss_next;
            rd_pend_reg  <= rd_pend_next;
            mul_pend_reg <= mul_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_tap_reg  <= rd_tap_next;
        rd_live_reg <= rd_live_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        plo_reg     <= plo_next;
        phi_reg     <= phi_next;
    end

endmodule

FILE: hw/rtl/saw_oscillator_fir_smoother_unit.sv
// top level: slot handshake, output register and slot parity
// the sample of a ticked slot request is offered on m_valid in the cycle after acceptance
// a first-of-pair slot does not start the engine; a second-of-pair slot starts the update,
// and no further request is taken until the engine is idle again, its run set by the shared
// multiply-accumulate over the tap ring (one ram read and one product per cycle)
// reset: aresetn low clears phase, ring pointer, parity and held sample; ring entries read
// as zero through per-entry valid flags, so no clearing pass is needed
module saw_oscillator_fir_smoother_unit
    import sos_pkg::*;
#(
    parameter int NUM_TAPS = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_slot_tick,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_sample_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready
);

    sos_cfg_t                   cfg;
    logic                       eng_busy;
    logic                       eng_start;
    logic signed [SAMPLE_W-1:0] held_sample;
    logic                       s_accept;
    logic                       tick_accept;
    logic                       m_valid_reg, m_valid_next;
    logic signed [SAMPLE_W-1:0] m_sample_reg, m_sample_next;
    logic                       parity_reg, parity_next;

    sos_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sos_engine #(
        .NUM_TAPS (NUM_TAPS)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .start       (eng_start),
        .busy        (eng_busy),
        .held_sample (held_sample)
    );

    assign s_ready      = !eng_busy && (!m_valid_reg || m_ready);
    assign s_accept     = s_valid && s_ready;
    assign tick_accept  = s_accept && s_slot_tick;
    assign eng_start    = tick_accept && parity_reg;
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;

    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        m_sample_next = m_sample_reg;
        parity_next   = parity_reg;
        if (tick_accept) begin
            m_valid_next  = 1'b1;
            m_sample_next = held_sample;
            parity_next   = !parity_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            parity_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            parity_reg  <= parity_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_sample_reg <= m_sample_next;
    end

endmodule

FILE: sim/sos_sample_checker.sv
// checker for the saw oscillator smoother: tracks config writes, predicts held samples, compares
`timescale 1ns / 100ps

module sos_sample_checker
    import sos_pkg::*;
#(
    parameter int NUM_TAPS = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic                       s_slot_tick,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [SAMPLE_W-1:0] m_sample_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output int                         fail_count,
    output int                         pending
);

    localparam int PRINT_CAP = 100;

    logic [STEP_W-1:0]          step_cfg  = PHASE_STEP_RST;
    logic [AMP_W-1:0]           amp_cfg   = AMPLITUDE_RST;
    logic [DATA_W-1:0]          taps_lo   = TAPS_LOW_RST;
    logic [DATA_W-1:0]          taps_hi   = TAPS_HIGH_RST;

    int                         saw_phase = 0;
    int                         tap_ring[RING_DEPTH];
    int                         ring_ptr  = 0;
    bit                         pair_half = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_hold = '0;
    logic signed [SAMPLE_W-1:0] sample_due[$];
    int                         errors = 0;

    initial begin
        foreach (tap_ring[i]) tap_ring[i] = 0;
    end

    task automatic flag_error(input string what);
        if (errors < PRINT_CAP) begin
            $display("%0t mismatch: %s", $time, what);
        end
        errors++;
    endtask

    function automatic longint tap_coef(input int k);
        logic [DATA_W-1:0]        word;
        logic signed [COEF_W-1:0] raw;
        word = (k < 4) ? taps_lo : taps_hi;
        raw  = word[(k % 4) * COEF_W +: COEF_W];
        return longint'(raw);
    endfunction

    // one oscillator update followed by the smoothing filter and output scaling
    task automatic smooth_step();
        longint acc;
        longint q;
        saw_phase += int'(step_cfg);
        if (saw_phase > int'(PHASE_ONE)) begin
            saw_phase -= int'(PHASE_TWO);
        end
        tap_ring[ring_ptr] = saw_phase;
        acc = 0;
        for (int k = 0; k < NUM_TAPS && k < RING_DEPTH; k++) begin
            acc += tap_coef(k) * longint'(tap_ring[(ring_ptr - k) & (RING_DEPTH - 1)]);
        end
        q = (acc * longint'(amp_cfg)) / (longint'(1) << 31);
        if (q > longint'(SAT_MAX)) begin
            q = longint'(SAT_MAX);
        end
        if (q < longint'(SAT_MIN)) begin
            q = longint'(SAT_MIN);
        end
        sample_hold = q[SAMPLE_W-1:0];
        ring_ptr = (ring_ptr + 1) & (RING_DEPTH - 1);
    endtask

    always @(posedge aclk) begin
        logic signed [SAMPLE_W-1:0] want;
        if (!aresetn) begin
            step_cfg    = PHASE_STEP_RST;
            amp_cfg     = AMPLITUDE_RST;
            taps_lo     = TAPS_LOW_RST;
            taps_hi     = TAPS_HIGH_RST;
            saw_phase   = 0;
            foreach (tap_ring[i]) tap_ring[i] = 0;
            ring_ptr    = 0;
            pair_half   = 1'b0;
            sample_hold = '0;
            sample_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1 -: REG_IDX_W])
                    REG_PHASE_STEP: step_cfg = pwdata[STEP_W-1:0];
                    REG_AMPLITUDE:  amp_cfg  = pwdata[AMP_W-1:0];
                    REG_TAPS_LOW:   taps_lo  = pwdata;
                    REG_TAPS_HIGH:  taps_hi  = pwdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready && s_slot_tick) begin
                sample_due.push_back(sample_hold);
                if (pair_half) begin
                    smooth_step();
                end
                pair_half = !pair_half;
            end
            if (m_valid && m_ready) begin
                if (sample_due.size() == 0) begin
                    flag_error($sformatf("sample %0d with no request waiting", m_sample_out));
                end else begin
                    want = sample_due.pop_front();
                    if (m_sample_out !== want) begin
                        flag_error($sformatf("sample_out got %0d expected %0d",
                                             m_sample_out, want));
                    end
                end
            end
        end
        pending    <= sample_due.size();
        fail_count <= errors;
    end

endmodule

FILE: sim/tb_saw_oscillator_fir_smoother_unit.sv
// testbench top: clock, reset, slot requests, register writes, result stalls and verdict
`timescale 1ns / 100ps

module tb_saw_oscillator_fir_smoother_unit
    import sos_pkg::*;
();

    localparam int TAPS_USED     = 8;
    localparam int ITEM_TARGET   = 1650;
    localparam int SETTLE_CYCLES = TAPS_USED + 8 + 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_slot_tick;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [SAMPLE_W-1:0] m_sample_out;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [DATA_W-1:0]          pwdata;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;

    int fail_count;
    int pending;
    int idle_run   = 0;
    int burst_left = 0;
    int items_sent = 0;
    bit hold_req   = 1'b0;

    saw_oscillator_fir_smoother_unit #(
        .NUM_TAPS(TAPS_USED)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_slot_tick  (s_slot_tick),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    sos_sample_checker #(
        .NUM_TAPS(TAPS_USED)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_slot_tick  (s_slot_tick),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (psel && penable && pwrite && pready)) begin
            idle_run <= 0;
        end else begin
            idle_run <= idle_run + 1;
        end
        if (idle_run >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: stall pattern changes every stretch, long hold-off on request
    initial begin
        int mode;
        int stretch;
        mode    = 0;
        stretch = 0;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                if (stretch == 0) begin
                    mode    = $urandom_range(0, 3);
                    stretch = $urandom_range(20, 200);
                end
                stretch--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 7) != 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [STEP_W-1:0] step, input logic [AMP_W-1:0] amp,
                             input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
        write_reg(REG_PHASE_STEP, DATA_W'(step));
        write_reg(REG_AMPLITUDE, DATA_W'(amp));
        write_reg(REG_TAPS_LOW, lo);
        write_reg(REG_TAPS_HIGH, hi);
    endtask

    task automatic offer_slot(input logic tick);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 32);
        end
        s_valid     <= 1'b1;
        s_slot_tick <= tick;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        items_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] random_taps();
        logic [DATA_W-1:0] word;
        int                sel;
        sel  = $urandom_range(0, 5);
        word = '0;
        for (int k = 0; k < 4; k++) begin
            case (sel)
                0:       word[k*COEF_W +: COEF_W] = '0;
                1:       word[k*COEF_W +: COEF_W] = COEF_W'($urandom);
                2:       word[k*COEF_W +: COEF_W] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                default: word[k*COEF_W +: COEF_W] = COEF_W'($urandom_range(0, 8191)) - 16'd4096;
            endcase
        end
        return word;
    endfunction

    initial begin
        logic [STEP_W-1:0] step;
        logic [AMP_W-1:0]  amp;
        int                phase_len;
        int                slots;
        int                phase_no;

        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_slot_tick <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, idle slots mixed in
        offer_slot(1'b1);
        offer_slot(1'b0);
        offer_slot(1'b1);
        offer_slot(1'b1);
        offer_slot(1'b0);
        offer_slot(1'b1);
        settle();

        // full step, full gain, largest positive taps: positive saturation
        write_cfg(16'hFFFF, 15'h7FFF, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF);
        repeat (4) offer_slot(1'b1);
        offer_slot(1'b0);
        repeat (4) offer_slot(1'b1);
        settle();

        // most negative taps: negative saturation
        write_cfg(16'hFFFF, 15'h7FFF, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000);
        repeat (6) offer_slot(1'b1);
        settle();

        // zero step and zero gain
        write_cfg('0, '0, random_taps(), random_taps());
        repeat (4) offer_slot(1'b1);
        settle();

        phase_no = 0;
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 5))
                0:       step = '0;
                1:       step = '1;
                2, 3:    step = STEP_W'($urandom_range(0, 2000));
                default: step = STEP_W'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0:       amp = '0;
                1:       amp = '1;
                2, 3:    amp = AMP_W'($urandom_range(1, 1000));
                default: amp = AMP_W'($urandom);
            endcase
            write_cfg(step, amp, random_taps(), random_taps());
            if (phase_no == 1 || phase_no == 6) begin
                hold_req = 1'b1;
            end
            phase_len = $urandom_range(60, 180);
            slots = 0;
            while (slots < phase_len && items_sent < ITEM_TARGET) begin
                offer_slot($urandom_range(0, 7) != 0);
                slots++;
            end
            settle();
            phase_no++;
        end

        repeat (4) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
